// ===== sv/array_list_deque_assert.svh =====
// Assertion macros shared by the array list deque RTL.
`ifndef ARRAY_LIST_DEQUE_ASSERT_SVH
`define ARRAY_LIST_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS

`define ALD_ASSERT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ALD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ALD_ASSERT(lbl, clk, rst_n, expr, msg)

`define ALD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/ald_pkg.sv =====
// Types and codes for the array list deque.
`default_nettype none

package ald_pkg;

  localparam int WORD_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LOWER,
    CELL_TAKE_UPPER
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

endpackage

`default_nettype wire

// ===== sv/ald_cell.sv =====
// One list position: holds a word, loads, or takes a neighbor's word.
`default_nettype none

module ald_cell
  import ald_pkg::*;
(
  input  wire logic     clk,
  input  wire cell_op_t op,
  input  wire word_t    load_data,
  input  wire word_t    lower_data,
  input  wire word_t    upper_data,
  output word_t         data_out
);

  word_t data_r;
  word_t data_nxt;

  always_comb begin
    case (op)
      CELL_LOAD:       data_nxt = load_data;
      CELL_TAKE_LOWER: data_nxt = lower_data;
      CELL_TAKE_UPPER: data_nxt = upper_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

`default_nettype wire

// ===== sv/array_list_deque.sv =====
// Array list deque top level: a row of word cells with a count and dump sequencer.
// Push and pop requests each give one result beat, registered in the cycle after acceptance.
// A dump of n elements gives n beats, one beat per cycle while the output is not stalled, rotating the cell row.
// A new request is taken once the dump has ended and the output register is free.
// Synchronous active-low reset empties the list; cell contents are not reset.
`default_nettype none

`include "array_list_deque_assert.svh"

module array_list_deque
  import ald_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic signed [WORD_W-1:0] in_push_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [WORD_W-1:0] out_elem_out,
  output logic [COUNT_W-1:0]       out_elem_count,
  output logic                     out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  word_t               out_elem_r, out_elem_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;

  logic   accept;
  logic   out_free;
  logic   dump_step;
  logic   full;
  logic   empty;
  word_t  load_data;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  word_t    slot_w  [CAPACITY];
  cell_op_t cell_op [CAPACITY];

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign dump_step = (state_r == ST_DUMP) && out_free;
  assign full      = (cnt_r == CAP_CNT);
  assign empty     = (cnt_r == '0);
  assign load_data = (state_r == ST_DUMP) ? slot_w[0] : in_push_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LO = (i == 0) ? 0 : i - 1;
    localparam int UP = (i == CAPACITY - 1) ? i : i + 1;
    localparam logic [CNT_W-1:0] IDX    = CNT_W'(i);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(i + 1);

    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (accept) begin
        case (in_req_type)
          REQ_PUSH_BACK: begin
            if (!full && IDX == cnt_r) cell_op[i] = CELL_LOAD;
          end
          REQ_PUSH_FRONT: begin
            if (!full) begin
              if (i == 0) cell_op[i] = CELL_LOAD;
              else if (IDX <= cnt_r) cell_op[i] = CELL_TAKE_LOWER;
            end
          end
          REQ_POP_FRONT: begin
            if (!empty && IDX_P1 < cnt_r) cell_op[i] = CELL_TAKE_UPPER;
          end
          default: cell_op[i] = CELL_HOLD;
        endcase
      end else if (dump_step) begin
        if (IDX_P1 < cnt_r) cell_op[i] = CELL_TAKE_UPPER;
        else if (IDX_P1 == cnt_r) cell_op[i] = CELL_LOAD;
      end
    end

    ald_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .load_data  (load_data),
      .lower_data (slot_w[LO]),
      .upper_data (slot_w[UP]),
      .data_out   (slot_w[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_status_nxt = STAT_OK;
          out_elem_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          case (in_req_type)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
              if (full) out_status_nxt = STAT_FULL;
              else cnt_nxt = cnt_r + 1'b1;
            end
            REQ_POP_BACK, REQ_POP_FRONT: begin
              if (empty) out_status_nxt = STAT_EMPTY;
              else cnt_nxt = cnt_r - 1'b1;
            end
            REQ_DUMP: begin
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rem_nxt       = cnt_r;
                state_nxt     = ST_DUMP;
              end
            end
            default: out_status_nxt = STAT_OK;
          endcase
          out_count_nxt = cnt_nxt;
        end
      end
      ST_DUMP: begin
        if (dump_step) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_elem_nxt   = slot_w[0];
          out_count_nxt  = cnt_r;
          out_last_nxt   = (rem_r == CNT_W'(1));
          rem_nxt        = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign count_ext      = {{COUNT_W{1'b0}}, out_count_r};
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_elem_out   = out_elem_r;
  assign out_elem_count = count_ext[COUNT_W-1:0];
  assign out_last       = out_last_r;

  `ALD_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CAP_CNT, "element count above capacity")
  `ALD_ASSERT(a_dump_rem, clk, rst_n, (state_r != ST_DUMP) || (rem_r != '0 && rem_r <= cnt_r), "dump remainder out of range")
  `ALD_ASSERT_NEXT(a_pop_dec, clk, rst_n, accept && !empty && (in_req_type == REQ_POP_BACK || in_req_type == REQ_POP_FRONT), cnt_r == $past(cnt_r) - 1'b1, "pop did not drop one element")
  `ALD_ASSERT_NEXT(a_push_inc, clk, rst_n, accept && !full && (in_req_type == REQ_PUSH_BACK || in_req_type == REQ_PUSH_FRONT), cnt_r == $past(cnt_r) + 1'b1, "push did not add one element")

endmodule

`default_nettype wire
